// ----- rtl/tlb_maintenance_and_tick_defines.svh -----
// Assertion macros shared by the TLB maintenance and tick block.
`ifndef TLB_MAINTENANCE_AND_TICK_DEFINES_SVH
`define TLB_MAINTENANCE_AND_TICK_DEFINES_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define TMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Assertion that the block holds even while reset is applied.
`define TMT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/tmt_pkg.sv -----
// Package with sizes, codes and entry layout of the TLB maintenance and tick block.
`timescale 1ns / 1ps
`default_nettype none
package tmt_pkg;

  localparam int TLB_ENTRIES = 32;
  localparam int TLB_AW      = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_WRREG = 3'd1;
  localparam logic [2:0] OP_RDREG = 3'd2;
  localparam logic [2:0] OP_TLBR  = 3'd3;
  localparam logic [2:0] OP_TLBWI = 3'd4;
  localparam logic [2:0] OP_TLBWR = 3'd5;
  localparam logic [2:0] OP_TLBP  = 3'd6;

  localparam logic [3:0] REG_INDEX    = 4'd0;
  localparam logic [3:0] REG_ENTRYLO0 = 4'd1;
  localparam logic [3:0] REG_ENTRYLO1 = 4'd2;
  localparam logic [3:0] REG_PAGEMASK = 4'd3;
  localparam logic [3:0] REG_WIRED    = 4'd4;
  localparam logic [3:0] REG_ENTRYHI  = 4'd5;
  localparam logic [3:0] REG_COUNT    = 4'd6;
  localparam logic [3:0] REG_COMPARE  = 4'd7;
  localparam logic [3:0] REG_RANDOM   = 4'd8;

  localparam logic [4:0]  RANDOM_TOP = 5'd31;
  localparam logic [31:0] COUNT_STEP = 32'd2;
  localparam int          G_HI_BIT   = 12;

  typedef struct packed {
    logic [31:0] mask;
    logic [63:0] hi;
    logic [31:0] lo_even;
    logic [31:0] lo_odd;
  } tlb_entry_t;

  localparam int ENTRY_W = $bits(tlb_entry_t);

endpackage
`default_nettype wire

// ----- rtl/tmt_in_if.sv -----
// Input channel: one operation per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface tmt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [3:0]  reg_select;
  logic [63:0] write_value;
  logic        cop_usable;

  modport source (output valid, operation, reg_select, write_value, cop_usable,
                  input ready);
  modport sink   (input valid, operation, reg_select, write_value, cop_usable,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/tmt_out_if.sv -----
// Output channel: one result per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface tmt_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic        unusable_fault;
  logic        timer_pending;

  modport source (output valid, read_value, unusable_fault, timer_pending,
                  input ready);
  modport sink   (input valid, read_value, unusable_fault, timer_pending,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/tlb_maintenance_and_tick.sv -----
// Top level: staging registers, timer tick and TLB maintenance over one entry RAM.
//
//  Channel | Direction | Contents
//  in_i    | sink      | operation, reg_select, write_value, cop_usable
//  out_o   | source    | read_value, unusable_fault, timer_pending
//
// Ticks, register accesses, TLB writes and refused operations complete from
// S_IDLE; a TLB read goes through S_LOAD (registered RAM read) and S_DONE.
// A probe reads every entry of the TLB RAM in turn in S_PROBE, then S_DONE.
// Reset clears per-entry valid bits at once; no clearing pass is needed.
// One transaction waits in a command register while a result waits in the
// output register; a stalled output holds completion of the current command.
`timescale 1ns / 1ps
`default_nettype none
`include "tlb_maintenance_and_tick_defines.svh"
module tlb_maintenance_and_tick (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  tmt_in_if.sink    in_i,
  tmt_out_if.source out_o
);
  import tmt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_PROBE,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  logic        cmd_valid_q, cmd_valid_d;
  logic [2:0]  cmd_op_q, cmd_op_d;
  logic [3:0]  cmd_sel_q, cmd_sel_d;
  logic [63:0] cmd_val_q, cmd_val_d;
  logic        cmd_usable_q, cmd_usable_d;

  logic [5:0]  index_q, index_d;
  logic        failed_q, failed_d;
  logic [4:0]  random_q, random_d;
  logic [5:0]  wired_q, wired_d;
  logic [63:0] entry_hi_q, entry_hi_d;
  logic [31:0] lo_even_q, lo_even_d;
  logic [31:0] lo_odd_q, lo_odd_d;
  logic [31:0] page_mask_q, page_mask_d;
  logic [31:0] count_q, count_d;
  logic [31:0] compare_q, compare_d;
  logic        timer_q, timer_d;

  logic [TLB_ENTRIES-1:0] valid_q, valid_d;
  logic                   rd_valid_q;
  logic                   hit_q, hit_d;
  logic [TLB_AW-1:0]      addr_q, addr_d;

  logic        out_valid_q, out_valid_d;
  logic [63:0] out_read_q, out_read_d;
  logic        out_fault_q, out_fault_d;
  logic        out_timer_q, out_timer_d;

  logic              ram_en, ram_we;
  logic [TLB_AW-1:0] ram_addr;
  tlb_entry_t        ram_wdata, ram_rdata, entry;

  logic        out_free, is_tlb, slot_hit, probe_match;
  logic [5:0]  slot;
  logic [63:0] reg_mux;

  tmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TLB_ENTRIES)
  ) u_tlb_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready           = !cmd_valid_q;
  assign out_o.valid          = out_valid_q;
  assign out_o.read_value     = out_read_q;
  assign out_o.unusable_fault = out_fault_q;
  assign out_o.timer_pending  = out_timer_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign is_tlb   = (cmd_op_q == OP_TLBR) || (cmd_op_q == OP_TLBWI) ||
                    (cmd_op_q == OP_TLBWR) || (cmd_op_q == OP_TLBP);
  assign slot     = (cmd_op_q == OP_TLBWR) ? {1'b0, random_q} : index_q;
  assign slot_hit = ({1'b0, slot} < 7'(TLB_ENTRIES));

  // An entry never written since reset reads as all zero.
  assign entry = rd_valid_q ? ram_rdata : '0;

  assign probe_match = (entry.hi[39:13] == entry_hi_q[39:13]) &&
                       (entry.hi[G_HI_BIT] || (entry.hi[7:0] == entry_hi_q[7:0]));

  always_comb begin
    ram_wdata.mask    = page_mask_q;
    ram_wdata.hi      = entry_hi_q & ~{32'h0, page_mask_q};
    ram_wdata.hi[G_HI_BIT] = lo_even_q[0] & lo_odd_q[0];
    ram_wdata.lo_even = lo_even_q;
    ram_wdata.lo_odd  = lo_odd_q;
  end

  always_comb begin
    unique case (cmd_sel_q)
      REG_INDEX:    reg_mux = {32'h0, failed_q, 25'h0, index_q};
      REG_ENTRYLO0: reg_mux = {32'h0, lo_even_q};
      REG_ENTRYLO1: reg_mux = {32'h0, lo_odd_q};
      REG_PAGEMASK: reg_mux = {32'h0, page_mask_q};
      REG_WIRED:    reg_mux = {58'h0, wired_q};
      REG_ENTRYHI:  reg_mux = entry_hi_q;
      REG_COUNT:    reg_mux = {32'h0, count_q};
      REG_COMPARE:  reg_mux = {32'h0, compare_q};
      REG_RANDOM:   reg_mux = {59'h0, random_q};
      default:      reg_mux = '0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cmd_valid_d  = cmd_valid_q;
    cmd_op_d     = cmd_op_q;
    cmd_sel_d    = cmd_sel_q;
    cmd_val_d    = cmd_val_q;
    cmd_usable_d = cmd_usable_q;
    index_d      = index_q;
    failed_d     = failed_q;
    random_d     = random_q;
    wired_d      = wired_q;
    entry_hi_d   = entry_hi_q;
    lo_even_d    = lo_even_q;
    lo_odd_d     = lo_odd_q;
    page_mask_d  = page_mask_q;
    count_d      = count_q;
    compare_d    = compare_q;
    timer_d      = timer_q;
    valid_d      = valid_q;
    hit_d        = hit_q;
    addr_d       = addr_q;
    out_read_d   = out_read_q;
    out_fault_d  = out_fault_q;
    out_timer_d  = out_timer_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_q) begin
          if (is_tlb && !cmd_usable_q) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_read_d  = '0;
              out_fault_d = 1'b1;
              out_timer_d = timer_q;
              cmd_valid_d = 1'b0;
            end
          end else if (cmd_op_q == OP_TLBR) begin
            ram_en   = slot_hit;
            ram_addr = slot[TLB_AW-1:0];
            hit_d    = slot_hit;
            state_d  = S_LOAD;
          end else if (cmd_op_q == OP_TLBP) begin
            ram_en   = 1'b1;
            ram_addr = '0;
            addr_d   = '0;
            failed_d = 1'b1;
            state_d  = S_PROBE;
          end else if (out_free) begin
            out_valid_d = 1'b1;
            out_read_d  = '0;
            out_fault_d = 1'b0;
            cmd_valid_d = 1'b0;
            case (cmd_op_q) inside
              OP_TICK: begin
                if (count_q == compare_q) begin
                  timer_d = 1'b1;
                end
                count_d = count_q + COUNT_STEP;
                if ({1'b0, random_q} <= wired_q) begin
                  random_d = RANDOM_TOP;
                end else begin
                  random_d = random_q - 5'd1;
                end
              end
              OP_WRREG: begin
                case (cmd_sel_q)
                  REG_INDEX: begin
                    index_d  = cmd_val_q[5:0];
                    failed_d = cmd_val_q[31];
                  end
                  REG_ENTRYLO0: lo_even_d   = cmd_val_q[31:0];
                  REG_ENTRYLO1: lo_odd_d    = cmd_val_q[31:0];
                  REG_PAGEMASK: page_mask_d = cmd_val_q[31:0];
                  REG_WIRED: begin
                    wired_d  = cmd_val_q[5:0];
                    random_d = RANDOM_TOP;
                  end
                  REG_ENTRYHI: entry_hi_d = cmd_val_q;
                  REG_COUNT:   count_d    = cmd_val_q[31:0];
                  REG_COMPARE: begin
                    compare_d = cmd_val_q[31:0];
                    timer_d   = 1'b0;
                  end
                  default: ;
                endcase
              end
              OP_RDREG: out_read_d = reg_mux;
              OP_TLBWI, OP_TLBWR: begin
                if (slot_hit) begin
                  ram_en   = 1'b1;
                  ram_we   = 1'b1;
                  ram_addr = slot[TLB_AW-1:0];
                  valid_d[slot[TLB_AW-1:0]] = 1'b1;
                end
              end
              default: ;
            endcase
            out_timer_d = timer_d;
          end
        end
      end
      S_LOAD: begin
        // An index beyond the TLB loads all-zero staging values.
        page_mask_d = hit_q ? entry.mask : '0;
        entry_hi_d  = hit_q ? (entry.hi & ~{32'h0, entry.mask}) : '0;
        lo_even_d   = hit_q ? {entry.lo_even[31:1], entry.hi[G_HI_BIT]} : '0;
        lo_odd_d    = hit_q ? {entry.lo_odd[31:1], entry.hi[G_HI_BIT]} : '0;
        state_d     = S_DONE;
      end
      S_PROBE: begin
        // Later entries overwrite earlier matches, so the highest match wins.
        if (probe_match) begin
          index_d  = 6'(addr_q);
          failed_d = 1'b0;
        end
        if (addr_q == TLB_AW'(TLB_ENTRIES - 1)) begin
          state_d = S_DONE;
        end else begin
          ram_en   = 1'b1;
          ram_addr = addr_q + 1'b1;
          addr_d   = addr_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_read_d  = '0;
          out_fault_d = 1'b0;
          out_timer_d = timer_q;
          cmd_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (in_i.valid && in_i.ready) begin
      cmd_valid_d  = 1'b1;
      cmd_op_d     = in_i.operation;
      cmd_sel_d    = in_i.reg_select;
      cmd_val_d    = in_i.write_value;
      cmd_usable_d = in_i.cop_usable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_valid_q <= 1'b0;
      index_q     <= '0;
      failed_q    <= 1'b0;
      random_q    <= RANDOM_TOP;
      wired_q     <= '0;
      entry_hi_q  <= '0;
      lo_even_q   <= '0;
      lo_odd_q    <= '0;
      page_mask_q <= '0;
      count_q     <= '0;
      compare_q   <= '0;
      timer_q     <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_valid_q <= cmd_valid_d;
      index_q     <= index_d;
      failed_q    <= failed_d;
      random_q    <= random_d;
      wired_q     <= wired_d;
      entry_hi_q  <= entry_hi_d;
      lo_even_q   <= lo_even_d;
      lo_odd_q    <= lo_odd_d;
      page_mask_q <= page_mask_d;
      count_q     <= count_d;
      compare_q   <= compare_d;
      timer_q     <= timer_d;
      valid_q     <= valid_d;
      if (ram_en && !ram_we) begin
        rd_valid_q <= valid_q[ram_addr];
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_op_q     <= cmd_op_d;
    cmd_sel_q    <= cmd_sel_d;
    cmd_val_q    <= cmd_val_d;
    cmd_usable_q <= cmd_usable_d;
    hit_q        <= hit_d;
    addr_q       <= addr_d;
    out_read_q   <= out_read_d;
    out_fault_q  <= out_fault_d;
    out_timer_q  <= out_timer_d;
  end

  `TMT_ASSERT(a_probe_op, (state_q == S_PROBE) |-> (cmd_valid_q && cmd_op_q == OP_TLBP),
              "probe sequencer running without a probe command")
  `TMT_ASSERT(a_ram_write, ram_we |-> (state_q == S_IDLE && cmd_valid_q && cmd_usable_q),
              "TLB RAM written outside a permitted TLB write")
  `TMT_ASSERT(a_fault_data, (out_valid_q && out_fault_q) |-> (out_read_q == '0),
              "refused transaction carries read data")
  `TMT_ASSERT(a_timer_clear,
              $fell(timer_q) |-> $past(cmd_op_q == OP_WRREG && cmd_sel_q == REG_COMPARE),
              "timer flag cleared without a compare write")
  `TMT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE && !out_valid_q),
                     "block not idle during reset")

endmodule
`default_nettype wire

// ----- rtl/tmt_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     en_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  output      logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule
`default_nettype wire
